FILE: src/wnd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wnd_pkg
// shared types and constants for the worley nth nearest distance unit
// ----------------------------------------------------------------------------
package wnd_pkg;

   // configuration register indexes
   localparam logic [1:0] REG_POINTS = 2'd0;
   localparam logic [1:0] REG_RANK   = 2'd1;
   localparam logic [1:0] REG_SCALE  = 2'd2;
   localparam logic [1:0] REG_GAIN   = 2'd3;

   // item opcodes
   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // commands from controller to datapath
   typedef struct packed {
      logic load_pos;    // register scaled pixel position
      logic clear_list;  // set sorted list to all ones
      logic calc;        // register differences of fetched point
      logic square;      // register squares
      logic sum;         // sum squares into distance
      logic insert;      // bubble distance into list
      logic sqrt_start;  // load root unit
      logic sqrt_step;   // one root iteration
      logic scale;       // multiply root by gain
      logic result;      // form final result
   } wnd_cmd_type;

endpackage
`default_nettype wire

FILE: src/wnd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wnd_ram
// generic single write port ram with registered read
// ----------------------------------------------------------------------------
module wnd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire [$clog2(DEPTH)-1:0]  wr_addr,
   input  wire [WIDTH-1:0]          wr_data,
   input  wire [$clog2(DEPTH)-1:0]  rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

FILE: src/wnd_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wnd_datapath
// distance arithmetic, sorted list, square root and output scale
// ----------------------------------------------------------------------------
module wnd_datapath #(
   parameter int MAX_RANK = 16
) (
   input  wire                       clock,
   input  wire wnd_pkg::wnd_cmd_type cmd,
   input  wire [$clog2(MAX_RANK)-1:0] rank,
   input  wire [11:0]                pixel_x,
   input  wire [11:0]                pixel_y,
   input  wire [23:0]                pixel_scale,
   input  wire [15:0]                height_gain,
   input  wire [31:0]                tab_x,
   input  wire [31:0]                tab_y,
   input  wire [31:0]                tab_z,
   input  wire                       too_few,
   output logic [31:0]               noise_value
);
   localparam int RW = $clog2(MAX_RANK);

   logic [35:0] pos_x_ff, pos_y_ff;
   logic [32:0] mag_x_ff, mag_y_ff, mag_z_ff;
   logic [64:0] sq_x_ff, sq_y_ff, sq_z_ff;  // bit 64 marks saturation
   logic [63:0] dist_ff;
   logic [63:0] list_ff [MAX_RANK];
   logic [63:0] rem_ff;
   logic [63:0] root_ff;
   logic [63:0] bit_ff;
   logic [47:0] prod_ff;

   logic [37:0] dx, dy;
   logic [37:0] ax, ay;
   logic [65:0] s2;
   logic [MAX_RANK-1:0] lt;
   logic [63:0] lnext [MAX_RANK];
   logic [63:0] trial;

   // signed difference and magnitude
   always_comb begin
      dx = {2'b00, pos_x_ff} - {{6{tab_x[31]}}, tab_x};
      dy = {2'b00, pos_y_ff} - {{6{tab_y[31]}}, tab_y};
      ax = dx[37] ? (38'd0 - dx) : dx;
      ay = dy[37] ? (38'd0 - dy) : dy;
   end

   function automatic logic [32:0] clip(input logic [37:0] m);
      clip = (m[37:32] != 6'd0) ? {1'b1, 32'd0} : {1'b0, m[31:0]};
   endfunction

   function automatic logic [64:0] sqs(input logic [32:0] m);
      logic [63:0] p;
      p = 64'(m[31:0]) * 64'(m[31:0]);
      sqs = m[32] ? {1'b1, 64'd0} : {1'b0, p};
   endfunction

   // sum of three squares, wide enough to flag overflow for saturation
   always_comb begin
      s2 = {2'b00, sq_x_ff[63:0]} + {2'b00, sq_y_ff[63:0]} + {2'b00, sq_z_ff[63:0]};
   end

   // sorted insertion: all compares in parallel, each entry takes itself,
   // the new distance or its lower neighbor
   always_comb begin
      for (int j = 0; j < MAX_RANK; j++) begin
         lt[j] = (RW'(j) <= rank) && (dist_ff < list_ff[j]);
      end
      lnext[0] = lt[0] ? dist_ff : list_ff[0];
      for (int j = 1; j < MAX_RANK; j++) begin
         if (!lt[j]) begin
            lnext[j] = list_ff[j];
         end else if (lt[j-1]) begin
            lnext[j] = list_ff[j-1];
         end else begin
            lnext[j] = dist_ff;
         end
      end
   end

   assign trial = root_ff + bit_ff;

   always_ff @(posedge clock) begin
      // scaled pixel position
      if (cmd.load_pos) begin
         pos_x_ff <= pixel_x * pixel_scale;
         pos_y_ff <= pixel_y * pixel_scale;
      end
      // magnitudes
      if (cmd.calc) begin
         mag_x_ff <= clip(ax);
         mag_y_ff <= clip(ay);
         mag_z_ff <= tab_z[31] ? {1'b0, 32'd0 - tab_z} : {1'b0, tab_z};
      end
      // squares
      if (cmd.square) begin
         sq_x_ff <= sqs(mag_x_ff);
         sq_y_ff <= sqs(mag_y_ff);
         sq_z_ff <= sqs(mag_z_ff);
      end
      if (cmd.sum) begin
         dist_ff <= (sq_x_ff[64] | sq_y_ff[64] | sq_z_ff[64] | (s2[65:64] != 2'd0))
                    ? '1 : s2[63:0];
      end
      // list
      for (int j = 0; j < MAX_RANK; j++) begin
         if (cmd.clear_list) begin
            list_ff[j] <= '1;
         end else if (cmd.insert) begin
            list_ff[j] <= lnext[j];
         end
      end
      // digit by digit square root
      if (cmd.sqrt_start) begin
         rem_ff  <= list_ff[rank];
         root_ff <= '0;
         bit_ff  <= 64'h4000_0000_0000_0000;
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
      if (cmd.scale) begin
         prod_ff <= root_ff[31:0] * height_gain;
      end
      if (cmd.result) begin
         if (too_few || prod_ff[47:40] != 8'd0) begin
            noise_value <= '1;
         end else begin
            noise_value <= prod_ff[39:8];
         end
      end
   end
endmodule
`default_nettype wire

FILE: src/wnd_controller.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wnd_controller
// sequencer for point walk, root iterations and result handshake
// ----------------------------------------------------------------------------
module wnd_controller #(
   parameter int MAX_POINTS = 256
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            req_tvalid,
   output logic                           req_tready,
   input  wire                            req_op,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   input  wire  [$clog2(MAX_POINTS):0]    n_points,
   output logic [$clog2(MAX_POINTS)-1:0]  rd_addr,
   output logic                           wr_en,
   output wnd_pkg::wnd_cmd_type           cmd
);
   localparam int AW = $clog2(MAX_POINTS);

   typedef enum logic [2:0] {
      S_IDLE, S_FETCH, S_SUM, S_DRAIN, S_SQRT, S_SCALE, S_RESULT, S_OUT
   } state_type;

   state_type      state_ff;
   logic [AW:0]    idx_ff;      // next point to fetch
   logic [AW:0]    left_ff;     // number of points to fetch
   logic [3:0]     pipe_v_ff;   // valid bits of calc/square/sum/insert
   logic [4:0]     step_ff;
   logic           rsp_v_ff;
   logic           fire;
   logic           issue;

   assign fire       = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE) && !rsp_v_ff;
   assign wr_en      = fire && (req_op == wnd_pkg::OP_LOAD);
   assign rsp_tvalid = rsp_v_ff;
   assign rd_addr    = idx_ff[AW-1:0];
   assign issue      = (state_ff == S_FETCH) && (idx_ff < left_ff);

   // datapath commands from the handshake, pipeline valid bits and state
   always_comb begin
      cmd            = '0;
      cmd.load_pos   = fire;
      cmd.clear_list = fire;
      cmd.calc       = pipe_v_ff[0];
      cmd.square     = pipe_v_ff[1];
      cmd.sum        = pipe_v_ff[2];
      cmd.insert     = pipe_v_ff[3];
      // list is final by the last drain step, which loads the root unit
      cmd.sqrt_start = (state_ff == S_DRAIN) && (step_ff == 5'd4);
      cmd.sqrt_step  = (state_ff == S_SQRT);
      cmd.scale      = (state_ff == S_SCALE);
      cmd.result     = (state_ff == S_RESULT);
   end

   // state, counters and output valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         idx_ff    <= '0;
         left_ff   <= '0;
         pipe_v_ff <= '0;
         step_ff   <= '0;
         rsp_v_ff  <= 1'b0;
      end else begin
         pipe_v_ff <= {pipe_v_ff[2:0], issue};
         if (rsp_v_ff && rsp_tready) begin
            rsp_v_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (fire && req_op == wnd_pkg::OP_QUERY) begin
                  idx_ff   <= '0;
                  left_ff  <= n_points;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: begin
               // the position registered at load_pos is ready in this state
               if (issue) begin
                  idx_ff <= idx_ff + 1'b1;
               end else begin
                  step_ff  <= '0;
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == 5'd4) begin
                  step_ff  <= '0;
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               step_ff <= step_ff + 1'b1;
               if (step_ff == 5'd31) begin
                  state_ff <= S_SCALE;
               end
            end
            S_SCALE: begin
               state_ff <= S_RESULT;
            end
            S_RESULT: begin
               rsp_v_ff <= 1'b1;
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end
endmodule
`default_nettype wire

FILE: src/worley_nth_nearest_distance_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// worley_nth_nearest_distance_unit
// fixed point worley noise, nth nearest feature point distance
// ----------------------------------------------------------------------------
// load item: written to the point table, no result
// query item: one point per cycle through the table read and square
//   pipeline for the N points in use, then a 32 step square root
// one query at a time; the next item is taken once the result has left
// reset: synchronous, clears control and configuration registers; point table is not cleared
module worley_nth_nearest_distance_unit #(
   parameter int MAX_POINTS = 256,
   parameter int MAX_RANK   = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   // tdata: point_slot[7:0] point_x[39:8] point_y[71:40] point_z[103:72]
   //        pixel_x[115:104] pixel_y[127:116]
   input  wire [127:0] req_tdata,
   // tuser: opcode
   input  wire         req_tuser,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // tdata: noise_value[31:0]
   output logic [31:0] rsp_tdata,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire [1:0]   csr_index,
   input  wire [31:0]  csr_data
);
   localparam int AW = $clog2(MAX_POINTS);
   localparam int RW = $clog2(MAX_RANK);

   logic [8:0]  points_ff;
   logic [3:0]  rank_ff;
   logic [23:0] scale_ff;
   logic [15:0] gain_ff;
   logic [AW:0] n_pts;
   logic [RW-1:0] rank_c;
   logic        too_few;
   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_slot;
   logic        wr_en;
   logic [31:0] tx, ty, tz;
   logic [11:0] px_ff, py_ff;
   wnd_pkg::wnd_cmd_type cmd;

   assign csr_ready = 1'b1;

   // slot taken modulo the table depth
   assign wr_slot = AW'(req_tdata[7:0]);

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= 9'd1;
         rank_ff   <= 4'd0;
         scale_ff  <= 24'd65536;
         gain_ff   <= 16'd256;
      end else if (csr_valid) begin
         case (csr_index)
            wnd_pkg::REG_POINTS: points_ff <= csr_data[8:0];
            wnd_pkg::REG_RANK:   rank_ff   <= csr_data[3:0];
            wnd_pkg::REG_SCALE:  scale_ff  <= csr_data[23:0];
            wnd_pkg::REG_GAIN:   gain_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // clamp count and rank, flag too few points for the rank
   always_comb begin
      if (32'(points_ff) > MAX_POINTS) n_pts = (AW+1)'(MAX_POINTS);
      else n_pts = (AW+1)'(points_ff);
      if (32'(rank_ff) > MAX_RANK - 1) rank_c = RW'(MAX_RANK - 1);
      else rank_c = RW'(rank_ff);
      too_few = (32'(n_pts) <= 32'(rank_c));
   end

   // hold query pixel
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         px_ff <= req_tdata[115:104];
         py_ff <= req_tdata[127:116];
      end
   end

   wnd_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_x (
      .clock, .wr_en, .wr_addr(wr_slot), .wr_data(req_tdata[39:8]),
      .rd_addr, .rd_data(tx));
   wnd_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_y (
      .clock, .wr_en, .wr_addr(wr_slot), .wr_data(req_tdata[71:40]),
      .rd_addr, .rd_data(ty));
   wnd_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_ram_z (
      .clock, .wr_en, .wr_addr(wr_slot), .wr_data(req_tdata[103:72]),
      .rd_addr, .rd_data(tz));

   wnd_controller #(.MAX_POINTS(MAX_POINTS)) u_ctrl (
      .clock, .reset, .req_tvalid, .req_tready, .req_op(req_tuser),
      .rsp_tvalid, .rsp_tready, .n_points(n_pts), .rd_addr, .wr_en, .cmd);

   wnd_datapath #(.MAX_RANK(MAX_RANK)) u_dp (
      .clock, .cmd, .rank(rank_c), .pixel_x(cmd.load_pos ? req_tdata[115:104] : px_ff),
      .pixel_y(cmd.load_pos ? req_tdata[127:116] : py_ff),
      .pixel_scale(scale_ff), .height_gain(gain_ff),
      .tab_x(tx), .tab_y(ty), .tab_z(tz), .too_few, .noise_value(rsp_tdata));
endmodule
`default_nettype wire

FILE: src/wnd_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wnd_props
// port level checks for the worley unit
// ----------------------------------------------------------------------------
module wnd_props (
   input wire        clock,
   input wire        reset,
   input wire        req_tvalid,
   input wire        req_tready,
   input wire        req_tuser,
   input wire        rsp_tvalid,
   input wire        rsp_tready,
   input wire [31:0] rsp_tdata
);
   // result holds while stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // no new item while a result waits
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("ready while result pending");
   // a query never gives a result in the next cycle
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tuser |=> !rsp_tvalid)
      else $error("result too early");
   // a load gives no result
   a_load: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tuser |=> !rsp_tvalid)
      else $error("load made a result");
endmodule

bind worley_nth_nearest_distance_unit wnd_props u_chk (
   .clock, .reset, .req_tvalid, .req_tready, .req_tuser,
   .rsp_tvalid, .rsp_tready, .rsp_tdata);
`default_nettype wire

FILE: test/wnd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wnd_checker
// Watches the request, result and register channels of the worley nth
// nearest distance unit. It keeps its own point table and register copies,
// predicts the noise value of every query, and compares each result in order.
// ----------------------------------------------------------------------------
module wnd_checker (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire [127:0] req_tdata,
   input  wire         req_tuser,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire [31:0]  rsp_tdata,
   input  wire         csr_valid,
   input  wire         csr_ready,
   input  wire [1:0]   csr_index,
   input  wire [31:0]  csr_data,
   output int          fail_count,
   output int          pending
);

   localparam int NPTS  = 256;
   localparam int NRANK = 16;

   // shadow point table and registers
   logic [31:0] pt_x [NPTS];
   logic [31:0] pt_y [NPTS];
   logic [31:0] pt_z [NPTS];
   logic [8:0]  cfg_points;
   logic [3:0]  cfg_rank;
   logic [23:0] cfg_scale;
   logic [15:0] cfg_gain;

   logic [31:0] noise_fifo [$];
   int          query_count;

   initial begin
      fail_count = 0;
      pending = 0;
      query_count = 0;
   end

   // squared coordinate difference, saturating to all ones
   function automatic logic [63:0] sq_clip(longint d);
      logic [63:0] m;
      m = (d < 0) ? 64'(-d) : 64'(d);
      if (m > 64'hFFFF_FFFF) return '1;
      return m * m;
   endfunction

   function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
   endfunction

   // floored square root, bit by bit
   function automatic logic [31:0] floor_root(logic [63:0] v);
      logic [63:0] rem, r, b;
      rem = v;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > rem) b = b >> 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r[31:0];
   endfunction

   // nth nearest distance times gain for one pixel
   function automatic logic [31:0] noise_at(logic [11:0] px, logic [11:0] py);
      logic [63:0] nearest [NRANK];
      logic [63:0] d, t, prod;
      longint      fx, fy;
      int          n, rank;
      logic [31:0] root;
      n = (cfg_points > NPTS) ? NPTS : int'(cfg_points);
      rank = int'(cfg_rank);
      fx = longint'(px) * longint'(cfg_scale);
      fy = longint'(py) * longint'(cfg_scale);
      for (int j = 0; j < NRANK; j++) nearest[j] = '1;
      for (int i = 0; i < n; i++) begin
         d = sq_clip(fx - longint'($signed(pt_x[i])));
         d = add_clip(d, sq_clip(fy - longint'($signed(pt_y[i]))));
         d = add_clip(d, sq_clip(longint'($signed(pt_z[i]))));
         // bubble into sorted list, equal distances keep order
         for (int j = 0; j <= rank; j++) begin
            if (d < nearest[j]) begin
               t = nearest[j];
               nearest[j] = d;
               d = t;
            end
         end
      end
      if (n <= rank) return 32'hFFFF_FFFF;
      root = floor_root(nearest[rank]);
      prod = (64'(root) * 64'(cfg_gain)) >> 8;
      return (prod > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : prod[31:0];
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // watch all channels at each rising edge
   always @(posedge clock) begin
      logic [31:0] want;
      logic [7:0]  slot;
      if (reset) begin
         cfg_points <= 9'd1;
         cfg_rank   <= 4'd0;
         cfg_scale  <= 24'd65536;
         cfg_gain   <= 16'd256;
         noise_fifo.delete();
         pending <= 0;
      end else begin
         // result item against oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            if (noise_fifo.size() == 0) begin
               report_mismatch($sformatf("result %h with no query waiting", rsp_tdata));
            end else begin
               want = noise_fifo.pop_front();
               if (rsp_tdata !== want)
                  report_mismatch($sformatf("noise_value %h, predicted %h",
                                            rsp_tdata, want));
            end
         end
         // request item
         if (req_tvalid && req_tready) begin
            if (req_tuser == wnd_pkg::OP_LOAD) begin
               slot = req_tdata[7:0];
               pt_x[slot] = req_tdata[39:8];
               pt_y[slot] = req_tdata[71:40];
               pt_z[slot] = req_tdata[103:72];
            end else begin
               noise_fifo.push_back(noise_at(req_tdata[115:104], req_tdata[127:116]));
               query_count++;
            end
         end
         // register write
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wnd_pkg::REG_POINTS: cfg_points <= csr_data[8:0];
               wnd_pkg::REG_RANK:   cfg_rank   <= csr_data[3:0];
               wnd_pkg::REG_SCALE:  cfg_scale  <= csr_data[23:0];
               wnd_pkg::REG_GAIN:   cfg_gain   <= csr_data[15:0];
               default: ;
            endcase
         end
         pending <= noise_fifo.size();
      end
   end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the worley nth nearest distance unit: fills the point table,
// runs directed corner queries, then random register phases with mixed load
// and query items under random sender gaps and receiver stalls. The checker
// beside the block predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int SETTLE = 80;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [127:0] req_tdata;
   logic         req_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [31:0]  rsp_tdata;
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_index;
   logic [31:0]  csr_data;
   int           fail_count;
   int           pending;
   int           burst_left;
   logic         stall_free;

   worley_nth_nearest_distance_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   wnd_checker u_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   initial begin
      #20ms;
      $display("** worley_nth_nearest_distance_unit: FAILED **");
      $finish;
   end

   // receiver stalls: random masks, with stall free stretches
   initial begin
      logic [15:0] mask;
      rsp_tready = 1'b0;
      stall_free = 1'b0;
      forever begin
         mask = $urandom;
         stall_free = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < 16; i++) begin
            @(negedge clock);
            rsp_tready <= stall_free | mask[i];
         end
      end
   end

   // one item, called at a falling edge; valid stays high on return
   task automatic send_item(logic op, logic [7:0] slot, logic [31:0] x,
                            logic [31:0] y, logic [31:0] z,
                            logic [11:0] px, logic [11:0] py);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 20);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {py, px, z, y, x, slot};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   task automatic load_point(logic [7:0] slot, logic [31:0] x, logic [31:0] y,
                             logic [31:0] z);
      send_item(wnd_pkg::OP_LOAD, slot, x, y, z, 12'd0, 12'd0);
   endtask

   task automatic query_pixel(logic [11:0] px, logic [11:0] py);
      send_item(wnd_pkg::OP_QUERY, $urandom, $urandom, $urandom, $urandom, px, py);
   endtask

   // stop sending and wait until every result is back and the block settles
   task automatic drain();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(logic [8:0] npts, logic [3:0] rank, logic [23:0] scale,
                           logic [15:0] gain);
      drain();
      write_reg(wnd_pkg::REG_POINTS, {23'd0, npts});
      write_reg(wnd_pkg::REG_RANK, {28'd0, rank});
      write_reg(wnd_pkg::REG_SCALE, {8'd0, scale});
      write_reg(wnd_pkg::REG_GAIN, {16'd0, gain});
   endtask

   // coordinate: full range, near the pixel grid, or an extreme
   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2:    return 32'h8000_0000;
         3:    return 32'h7FFF_FFFF;
         default: return $urandom_range(0, 32'h00FF_FFFF);
      endcase
   endfunction

   function automatic logic [31:0] rand_zoff();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'd0;
         default: return $signed($urandom_range(0, 32'h0003_FFFF)) - 32'sh0002_0000;
      endcase
   endfunction

   function automatic logic [23:0] rand_scale();
      case ($urandom_range(0, 5))
         0: return 24'd0;
         1: return 24'hFF_FFFF;
         2: return $urandom;
         default: return $urandom_range(1, 24'h04_0000);
      endcase
   endfunction

   function automatic logic [8:0] rand_points();
      case ($urandom_range(0, 11))
         0: return 9'd256;
         1: return $urandom_range(257, 511);
         2: return 9'd0;
         3: return $urandom_range(40, 255);
         default: return $urandom_range(1, 24);
      endcase
   endfunction

   initial begin
      logic [3:0]  rank;
      logic [8:0]  npts;
      logic [15:0] gain;
      int          phase_items;
      req_tvalid = 1'b0;
      req_tuser  = wnd_pkg::OP_LOAD;
      req_tdata  = '0;
      csr_valid  = 1'b0;
      csr_index  = wnd_pkg::REG_POINTS;
      csr_data   = '0;
      burst_left = 0;
      reset = 1'b1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // fill every slot so no query reads an unwritten entry
      for (int s = 0; s < 256; s++) load_point(s[7:0], rand_coord(), rand_coord(),
                                               rand_zoff());

      // directed: extreme points, reset registers, corner pixels
      load_point(8'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
      load_point(8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
      load_point(8'd1, 32'd0, 32'd0, 32'd0);
      query_pixel(12'd0, 12'd0);
      query_pixel(12'hFFF, 12'hFFF);
      // too few points for the rank
      set_regs(9'd3, 4'd15, 24'h01_0000, 16'hFFFF);
      query_pixel(12'd5, 12'd7);
      // zero points searched
      set_regs(9'd0, 4'd0, 24'h01_0000, 16'd256);
      query_pixel(12'd1, 12'd2);
      // point count above table size is clamped, max rank
      set_regs(9'd511, 4'd15, 24'hFF_FFFF, 16'hFFFF);
      query_pixel(12'hFFF, 12'd0);
      query_pixel(12'd0, 12'hFFF);
      // zero scale and zero gain
      set_regs(9'd256, 4'd0, 24'd0, 16'd0);
      query_pixel(12'hABC, 12'h543);
      set_regs(9'd2, 4'd1, 24'd0, 16'hFFFF);
      query_pixel(12'd0, 12'd0);
      load_point(8'd1, 32'd0, 32'd0, 32'd0);
      query_pixel(12'h555, 12'hAAA);

      // random register phases with mixed items
      for (int p = 0; p < 12; p++) begin
         npts = rand_points();
         rank = (p == 0) ? 4'd0 : (p == 1) ? 4'd15 : 4'($urandom_range(0, 15));
         gain = (p == 2) ? 16'hFFFF : (p == 3) ? 16'd0 : 16'($urandom);
         set_regs(npts, rank, rand_scale(), gain);
         phase_items = (npts > 64) ? 30 : 95;
         for (int i = 0; i < phase_items; i++) begin
            if ($urandom_range(0, 9) < 3)
               load_point($urandom, rand_coord(), rand_coord(), rand_zoff());
            else
               query_pixel($urandom, $urandom);
         end
      end

      // end of stimulus
      drain();
      if (fail_count == 0 && pending == 0) begin
         $display("** worley_nth_nearest_distance_unit: PASSED **");
      end else begin
         $display("** worley_nth_nearest_distance_unit: FAILED **");
      end
      $finish;
   end

endmodule
